>>> rtl/core/cktab_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the compacting key table
package cktab_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS   = 32;
  localparam int OP_BITS    = 2;
  localparam int ST_BITS    = 2;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  localparam logic [OP_BITS-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

  localparam logic [ST_BITS-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_BITS-1:0] ST_MISSING = 2'd1;
  localparam logic [ST_BITS-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]         operation;
    logic signed [KEY_BITS-1:0] key;
  } req_t;

  typedef struct packed {
    logic [ST_BITS-1:0]  status;
    logic [IDX_BITS-1:0] position;
    logic [CNT_BITS-1:0] entry_count;
  } rsp_t;

  // broadcast from the control to every cell of the chain
  typedef struct packed {
    logic                  shift;
    logic                  write;
    logic [CNT_BITS-1:0]   count;
    logic [VALUE_BITS-1:0] key;
  } cmd_t;

  // sign-extend the key, then keep the low VALUE_BITS bits
  function automatic logic [VALUE_BITS-1:0] key_word(input logic signed [KEY_BITS-1:0] k);
    logic signed [63:0] ext;
    ext = 64'(k);
    return ext[VALUE_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/cktab_cell.sv
`timescale 1ns / 1ps
// one storage cell of the key chain: holds a word, compares, shifts down
module cktab_cell (
  input  logic                                clk,
  input  cktab_pkg::cmd_t                     cmd,
  input  logic [cktab_pkg::IDX_BITS-1:0]      index,
  input  logic [cktab_pkg::VALUE_BITS-1:0]    right_word,
  input  logic                                hit_in,
  output logic                                hit_out,
  output logic [cktab_pkg::VALUE_BITS-1:0]    word
);

  logic occupied;
  logic at_tail;

  assign at_tail  = ({1'b0, index} == cmd.count);
  assign occupied = ({1'b0, index} < cmd.count);
  assign hit_out  = hit_in | (occupied && (word == cmd.key));

  // on delete, every cell at or above the first match takes its neighbor's word
  always_ff @(posedge clk) begin
    if (cmd.shift && hit_out) begin
      word <= right_word;
    end else if (cmd.write && at_tail) begin
      word <= cmd.key;
    end
  end

endmodule

>>> rtl/core/compacting_key_table_top.sv
`timescale 1ns / 1ps
// top level of the compacting key table: cell chain, count and result register
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------------
//   request | req_valid | req_stall | req: operation, key
//   result  | rsp_valid | rsp_stall | rsp: status, position, entry_count
//
// one request completes in the cycle it is accepted; its result is registered
// and shown the next cycle, so a new request can be taken every unstalled cycle
// the path that sets the clock is the key compare in every cell followed by
// the first-match chain that ripples through all DEPTH cells
// rst (synchronous) empties the table by clearing the count; stored words keep
// their old contents and are never read before they are written again
// a request is held off only while a result waits and the result side stalls
module compacting_key_table_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  cktab_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output cktab_pkg::rsp_t rsp
);

  logic [cktab_pkg::CNT_BITS-1:0] count;
  logic [cktab_pkg::CNT_BITS-1:0] count_next;
  cktab_pkg::rsp_t                rsp_next;
  cktab_pkg::cmd_t                cmd;

  logic                               accept;
  logic                               is_insert;
  logic                               is_delete;
  logic                               full;
  logic                               found;
  logic [cktab_pkg::IDX_BITS-1:0]     hit_pos;
  logic [cktab_pkg::DEPTH:0]          hit;
  logic [cktab_pkg::VALUE_BITS-1:0]   words [cktab_pkg::DEPTH];

  // accept unless a finished result is still waiting to be taken
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign is_insert = (req.operation == cktab_pkg::OP_INSERT);
  assign is_delete = (req.operation == cktab_pkg::OP_DELETE);
  assign full      = (count == cktab_pkg::CNT_BITS'(cktab_pkg::DEPTH));

  // broadcast to the cells; on insert only the cell at the tail position writes
  assign cmd.shift = accept && is_delete;
  assign cmd.write = accept && is_insert;
  assign cmd.count = count;
  assign cmd.key   = cktab_pkg::key_word(req.key);

  // match chain starts clear at cell 0
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < cktab_pkg::DEPTH; i++) begin : g_cell
    logic [cktab_pkg::VALUE_BITS-1:0] right_word;

    if (i == cktab_pkg::DEPTH - 1) begin : g_last
      assign right_word = words[i];
    end else begin : g_mid
      assign right_word = words[i+1];
    end

    cktab_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .index      (cktab_pkg::IDX_BITS'(i)),
      .right_word (right_word),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .word       (words[i])
    );
  end

  assign found = hit[cktab_pkg::DEPTH];

  // the first match is where the chain turns on; only one cell sees that edge
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < cktab_pkg::DEPTH; i++) begin
      if (hit[i+1] && !hit[i]) begin
        hit_pos = hit_pos | cktab_pkg::IDX_BITS'(i);
      end
    end
  end

  // result and new count; unused operation code behaves as search
  always_comb begin
    rsp_next.status      = cktab_pkg::ST_DONE;
    rsp_next.position    = '0;
    count_next           = count;
    if (is_insert) begin
      if (full) begin
        rsp_next.status = cktab_pkg::ST_FULL;
      end else begin
        rsp_next.position = count[cktab_pkg::IDX_BITS-1:0];
        count_next        = count + 1'b1;
      end
    end else if (is_delete) begin
      if (found) begin
        rsp_next.position = hit_pos;
        count_next        = count - 1'b1;
      end else begin
        rsp_next.status = cktab_pkg::ST_MISSING;
      end
    end else begin
      if (found) begin
        rsp_next.position = hit_pos;
      end else begin
        rsp_next.status = cktab_pkg::ST_MISSING;
      end
    end
    rsp_next.entry_count = count_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of the compacting key table: directed and random requests
module testbench;

  // operation code the block treats as a search
  localparam logic [cktab_pkg::OP_BITS-1:0] OP_SPARE = 2'd3;

  // tracks table contents and the queue of results still owed by the block
  class key_table_board;
    logic [cktab_pkg::VALUE_BITS-1:0] slots [cktab_pkg::DEPTH];
    int unsigned fill;
    cktab_pkg::rsp_t owed [$];
    int errors;
    int accepted;
    int hits;
    int misses;
    int full_rejects;
    int times_full;

    function new();
      fill = 0;
      errors = 0;
      accepted = 0;
      hits = 0;
      misses = 0;
      full_rejects = 0;
      times_full = 0;
    endfunction

    // lowest valid position holding the word, or -1
    function int first_hit(logic [cktab_pkg::VALUE_BITS-1:0] word);
      for (int i = 0; i < int'(fill); i++)
        if (slots[i] == word)
          return i;
      return -1;
    endfunction

    // apply an accepted request to the table and queue the result it owes
    function void note_request(cktab_pkg::req_t r);
      logic signed [63:0] wide;
      logic [cktab_pkg::VALUE_BITS-1:0] word;
      int hit;
      cktab_pkg::rsp_t want;
      wide = 64'(r.key);
      word = wide[cktab_pkg::VALUE_BITS-1:0];
      want = '0;
      want.status = cktab_pkg::ST_DONE;
      if (r.operation == cktab_pkg::OP_INSERT) begin
        if (fill >= cktab_pkg::DEPTH) begin
          want.status = cktab_pkg::ST_FULL;
          full_rejects++;
        end else begin
          want.position = cktab_pkg::IDX_BITS'(fill);
          slots[fill] = word;
          fill++;
          if (fill == cktab_pkg::DEPTH)
            times_full++;
        end
      end else begin
        hit = first_hit(word);
        if (hit < 0) begin
          want.status = cktab_pkg::ST_MISSING;
          misses++;
        end else begin
          hits++;
          want.position = cktab_pkg::IDX_BITS'(hit);
          // delete closes the gap by moving later entries down
          if (r.operation == cktab_pkg::OP_DELETE) begin
            for (int i = hit; i + 1 < int'(fill); i++)
              slots[i] = slots[i + 1];
            fill--;
          end
        end
      end
      want.entry_count = cktab_pkg::CNT_BITS'(fill);
      accepted++;
      owed.push_back(want);
    endfunction

    function void report(string field, int exp, int act);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp, act);
    endfunction

    // compare an accepted result with the oldest owed one
    function void check_result(cktab_pkg::rsp_t got);
      cktab_pkg::rsp_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d position %0d count %0d",
                 $time, got.status, got.position, got.entry_count);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status)
        report("status", int'(want.status), int'(got.status));
      if (got.position !== want.position)
        report("position", int'(want.position), int'(got.position));
      if (got.entry_count !== want.entry_count)
        report("entry_count", int'(want.entry_count), int'(got.entry_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cktab_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cktab_pkg::rsp_t rsp;

  key_table_board board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  logic [31:0] key_pool [8];

  compacting_key_table_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // result side: random stall, changed on the falling edge
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // result monitor: a result counts when valid and not stalled at the edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      board.check_result(rsp);
  end

  // offer one request, starting and ending at a falling edge
  // valid only drops for idle cycles, so back-to-back requests keep it high
  task automatic send_req(input logic [cktab_pkg::OP_BITS-1:0] op, input logic [31:0] k);
    cktab_pkg::req_t r;
    r.operation = op;
    r.key = k;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req <= '0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    board.note_request(r);
    @(negedge clk);
  endtask

  // hold off requests until every owed result has come back
  task automatic wait_drained();
    int guard;
    guard = 0;
    req_valid <= 1'b0;
    while (board.owed.size() != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  // random request shaped by mode: 0 fills the table, 1 drains it, 2 mixes
  task automatic send_random(input int mode);
    int roll;
    int pick;
    logic [cktab_pkg::OP_BITS-1:0] op;
    logic [31:0] k;
    roll = $urandom_range(99);
    case (mode)
      0: begin
        if (roll < 82) op = cktab_pkg::OP_INSERT;
        else if (roll < 90) op = cktab_pkg::OP_SEARCH;
        else if (roll < 96) op = cktab_pkg::OP_DELETE;
        else op = OP_SPARE;
      end
      1: begin
        if (roll < 72) op = cktab_pkg::OP_DELETE;
        else if (roll < 82) op = cktab_pkg::OP_INSERT;
        else if (roll < 95) op = cktab_pkg::OP_SEARCH;
        else op = OP_SPARE;
      end
      default: begin
        if (roll < 34) op = cktab_pkg::OP_INSERT;
        else if (roll < 64) op = cktab_pkg::OP_SEARCH;
        else if (roll < 95) op = cktab_pkg::OP_DELETE;
        else op = OP_SPARE;
      end
    endcase
    // keys: mostly ones in the table or a small pool, so hits and duplicates occur
    pick = $urandom_range(99);
    if (pick < 45 && board.fill > 0)
      k = board.slots[$urandom_range(board.fill - 1)];
    else if (pick < 75)
      k = key_pool[$urandom_range(7)];
    else
      k = $urandom;
    send_req(op, k);
  endtask

  initial begin
    logic [cktab_pkg::OP_BITS-1:0] dir_op [20];
    logic [31:0] dir_key [20];
    board = new();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 8; i++)
      key_pool[i] = $urandom;

    // empty table, extreme keys, duplicates, deletes at front, middle and end
    dir_op = '{cktab_pkg::OP_SEARCH, cktab_pkg::OP_DELETE, OP_SPARE,
               cktab_pkg::OP_INSERT, cktab_pkg::OP_INSERT, cktab_pkg::OP_INSERT,
               cktab_pkg::OP_INSERT, cktab_pkg::OP_INSERT, cktab_pkg::OP_INSERT,
               cktab_pkg::OP_INSERT, cktab_pkg::OP_SEARCH, OP_SPARE,
               cktab_pkg::OP_DELETE, cktab_pkg::OP_SEARCH, cktab_pkg::OP_DELETE,
               cktab_pkg::OP_SEARCH, cktab_pkg::OP_DELETE, cktab_pkg::OP_DELETE,
               cktab_pkg::OP_SEARCH, cktab_pkg::OP_INSERT};
    dir_key = '{32'd5, 32'd5, 32'd5, 32'h8000_0000, 32'h7fff_ffff,
                32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h5555_5555,
                32'haaaa_aaaa, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'haaaa_aaaa,
                32'd12345, 32'h0000_0000, 32'h0000_0001};

    // synchronous reset, released on a falling edge
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < 20; i++)
      send_req(dir_op[i], dir_key[i]);

    // four idling phases, each started from a drained block
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          send_idle_pct = 12;
          stall_pct = 12;
        end
      endcase
      for (int n = 0; n < 96; n++)
        send_random((n / 24) % 3);
    end

    wait_drained();
    stall_pct = 0;
    repeat (20) @(posedge clk);
    board.errors += board.owed.size();
    if (board.owed.size() != 0)
      $display("%0t: %0d results never arrived", $time, board.owed.size());

    $display("covered %0d requests: %0d hits, %0d not found, %0d rejected as full",
             board.accepted, board.hits, board.misses, board.full_rejects);
    $display("table filled to capacity %0d times; %0d check failures", board.times_full,
             board.errors);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("%0t: run timed out", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
